@@ rtl/core/gsc_pkg.sv @@
// Shared types, constants and helper functions for the gradient stop color sampler.
// Depends on nothing; every other file of the block refers to it by scoped names.
package gsc_pkg;

    localparam int MAX_STOPS     = 16;
    localparam int POSITION_BITS = 16;
    localparam int FRAC_BITS     = 16;
    localparam int CNT_W         = $clog2(MAX_STOPS + 1);
    localparam int IDX_W         = $clog2(MAX_STOPS);
    localparam int DIV_STEP_W    = $clog2(FRAC_BITS);
    localparam int COLOR_W       = 32;

    localparam logic [1:0] CMD_CLEAR  = 2'd0;
    localparam logic [1:0] CMD_INSERT = 2'd1;
    localparam logic [1:0] CMD_SAMPLE = 2'd2;

    typedef logic [POSITION_BITS-1:0] pos_t;
    typedef logic [COLOR_W-1:0]       color_t;
    typedef logic [FRAC_BITS:0]       frac_t;

    typedef struct packed {
        logic start;
        pos_t num;
        pos_t den;
    } div_req_t;

    typedef struct packed {
        logic   start;
        color_t color_a;
        color_t color_b;
        frac_t  frac;
    } lerp_req_t;

    // Fits the 16-bit port value to the stored position width.
    function automatic pos_t fit_position(input logic [15:0] value);
        logic [POSITION_BITS+15:0] wide;
        wide = {{POSITION_BITS{1'b0}}, value};
        return wide[POSITION_BITS-1:0];
    endfunction

endpackage

@@ rtl/core/gsc_table.sv @@
// Stop table storage: one write port and one registered read port into the sorted stop list.
// Depends on gsc_pkg for widths and types.
module gsc_table (
    input  logic                     clk,
    input  logic                     wr_en,
    input  logic [gsc_pkg::IDX_W-1:0] wr_addr,
    input  gsc_pkg::pos_t            wr_pos,
    input  gsc_pkg::color_t          wr_color,
    input  logic [gsc_pkg::IDX_W-1:0] rd_addr,
    output gsc_pkg::pos_t            rd_pos,
    output gsc_pkg::color_t          rd_color
);

    gsc_pkg::pos_t   pos_reg   [gsc_pkg::MAX_STOPS];
    gsc_pkg::color_t color_reg [gsc_pkg::MAX_STOPS];
    gsc_pkg::pos_t   rd_pos_reg;
    gsc_pkg::color_t rd_color_reg;

    // The read data is registered and appears in the cycle after the address; a read of an
    // entry that is written at the same edge returns the old contents.
    always_ff @(posedge clk)
    begin
        if (wr_en)
        begin
            pos_reg[wr_addr]   <= wr_pos;
            color_reg[wr_addr] <= wr_color;
        end
        rd_pos_reg   <= pos_reg[rd_addr];
        rd_color_reg <= color_reg[rd_addr];
    end

    assign rd_pos   = rd_pos_reg;
    assign rd_color = rd_color_reg;

endmodule

@@ rtl/core/gsc_div.sv @@
// Restoring divider that forms the segment fraction (num << 16) / den one bit a cycle.
// Depends on gsc_pkg for widths and the request struct.
module gsc_div (
    input  logic              clk,
    input  logic              rst_n,
    input  gsc_pkg::div_req_t req,
    output gsc_pkg::frac_t    quot,
    output logic              done
);

    gsc_pkg::pos_t                     rem_reg;
    gsc_pkg::pos_t                     den_reg;
    logic [gsc_pkg::FRAC_BITS-1:0]     quot_reg;
    logic [gsc_pkg::DIV_STEP_W-1:0]    step_reg;
    logic                              full_reg;
    logic                              busy_reg;
    logic                              done_reg;
    logic [gsc_pkg::POSITION_BITS:0]   rem_shift;
    logic [gsc_pkg::POSITION_BITS:0]   rem_diff;
    logic                              fits;

    always_comb
    begin
        rem_shift = {rem_reg, 1'b0};
        rem_diff  = rem_shift - {1'b0, den_reg};
        fits      = rem_shift >= {1'b0, den_reg};
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
        end
        else
        begin
            done_reg <= 1'b0;
            if (req.start)
            begin
                busy_reg <= 1'b1;
            end
            else if (busy_reg && step_reg == gsc_pkg::DIV_STEP_W'(gsc_pkg::FRAC_BITS - 1))
            begin
                busy_reg <= 1'b0;
                done_reg <= 1'b1;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (req.start)
        begin
            rem_reg  <= req.num;
            den_reg  <= req.den;
            full_reg <= req.num >= req.den;
            quot_reg <= '0;
            step_reg <= '0;
        end
        else if (busy_reg)
        begin
            if (fits)
            begin
                rem_reg <= rem_diff[gsc_pkg::POSITION_BITS-1:0];
            end
            else
            begin
                rem_reg <= rem_shift[gsc_pkg::POSITION_BITS-1:0];
            end
            quot_reg <= {quot_reg[gsc_pkg::FRAC_BITS-2:0], fits};
            step_reg <= step_reg + 1'b1;
        end
    end

    // When the distance reaches the whole segment the fraction is exactly one.
    assign quot = full_reg ? gsc_pkg::frac_t'(1) << gsc_pkg::FRAC_BITS : {1'b0, quot_reg};
    assign done = done_reg;

endmodule

@@ rtl/core/gsc_lerp.sv @@
// Channel-serial color interpolator with one shared signed multiplier.
// Depends on gsc_pkg for widths and the request struct.
module gsc_lerp (
    input  logic               clk,
    input  logic               rst_n,
    input  gsc_pkg::lerp_req_t req,
    output gsc_pkg::color_t    color,
    output logic               done
);

    gsc_pkg::color_t color_a_reg;
    gsc_pkg::color_t color_b_reg;
    gsc_pkg::frac_t  frac_reg;
    gsc_pkg::color_t result_reg;
    logic [1:0]      chan_reg;
    logic            phase_reg;
    logic            busy_reg;
    logic            done_reg;
    logic signed [26:0] prod_reg;

    logic [7:0]         chan_a;
    logic [7:0]         chan_b;
    logic signed [8:0]  diff;
    logic signed [26:0] prod_next;
    logic [26:0]        sum;

    // Channel a * (1 - f) + b * f is rewritten as a + (b - a) * f.
    always_comb
    begin
        chan_a    = color_a_reg[{chan_reg, 3'b000} +: 8];
        chan_b    = color_b_reg[{chan_reg, 3'b000} +: 8];
        diff      = $signed({1'b0, chan_b}) - $signed({1'b0, chan_a});
        prod_next = 27'(diff) * 27'($signed({1'b0, frac_reg}));
        sum       = {3'b000, chan_a, 16'h8000} + prod_reg;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg  <= 1'b0;
            done_reg  <= 1'b0;
            chan_reg  <= '0;
            phase_reg <= 1'b0;
        end
        else
        begin
            done_reg <= 1'b0;
            if (req.start)
            begin
                busy_reg  <= 1'b1;
                chan_reg  <= '0;
                phase_reg <= 1'b0;
            end
            else if (busy_reg)
            begin
                phase_reg <= ~phase_reg;
                if (phase_reg)
                begin
                    chan_reg <= chan_reg + 1'b1;
                    if (chan_reg == 2'd3)
                    begin
                        busy_reg <= 1'b0;
                        done_reg <= 1'b1;
                    end
                end
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (req.start)
        begin
            color_a_reg <= req.color_a;
            color_b_reg <= req.color_b;
            frac_reg    <= req.frac;
        end
        else if (busy_reg)
        begin
            if (!phase_reg)
            begin
                prod_reg <= prod_next;
            end
            else
            begin
                result_reg[{chan_reg, 3'b000} +: 8] <= sum[23:16];
            end
        end
    end

    assign color = result_reg;
    assign done  = done_reg;

endmodule

@@ rtl/core/gradient_stop_color_sampler.sv @@
// Top level of the gradient stop color sampler: command sequencer and result register.
// Depends on gsc_pkg, gsc_table, gsc_div and gsc_lerp.
//
//  Channel  | Valid      | Stall      | Payload
//  ---------+------------+------------+----------------------------------------------
//  command  | cmd_valid  | cmd_stall  | cmd, position, red, green, blue, alpha
//  result   | res_valid  | res_stall  | out_red, out_green, out_blue, out_alpha,
//           |            |            | out_overflow
//
// A clear only resets the stop count. An insert moves each larger stop up one slot, then
// writes the new one; the sorted insertion walks the table one entry a cycle.
// A sample scans the table one stop a cycle; if the position lies between two stops, the
// serial divider then holds the sequencer for the fraction and the shared multiplier for
// the four channels, and the result goes to the output register. The command channel
// stalls while a transaction is in progress. A finished result sits in the output register
// until it is taken, and the next command is accepted meanwhile. Reset clears the stop
// count and the overflow flag.
module gradient_stop_color_sampler (
    input  logic        clk,
    input  logic        rst_n,
    input  logic        cmd_valid,
    output logic        cmd_stall,
    input  logic [1:0]  cmd,
    input  logic [15:0] position,
    input  logic [7:0]  red,
    input  logic [7:0]  green,
    input  logic [7:0]  blue,
    input  logic [7:0]  alpha,
    output logic        res_valid,
    input  logic        res_stall,
    output logic [7:0]  out_red,
    output logic [7:0]  out_green,
    output logic [7:0]  out_blue,
    output logic [7:0]  out_alpha,
    output logic        out_overflow
);

    localparam logic [2:0] ST_IDLE = 3'd0;
    localparam logic [2:0] ST_INS  = 3'd1;
    localparam logic [2:0] ST_SCAN = 3'd2;
    localparam logic [2:0] ST_DIV  = 3'd3;
    localparam logic [2:0] ST_LERP = 3'd4;
    localparam logic [2:0] ST_DONE = 3'd5;

    logic [2:0]                 state_reg, state_next;
    logic [gsc_pkg::CNT_W-1:0]  count_reg, count_next;
    logic                       overflow_reg, overflow_next;
    logic [gsc_pkg::CNT_W-1:0]  walk_reg, walk_next;
    gsc_pkg::pos_t              t_reg, t_next;
    gsc_pkg::color_t            new_color_reg, new_color_next;
    gsc_pkg::pos_t              prev_pos_reg, prev_pos_next;
    gsc_pkg::color_t            prev_color_reg, prev_color_next;
    gsc_pkg::color_t            cur_color_reg, cur_color_next;
    gsc_pkg::color_t            result_reg, result_next;
    logic                       res_valid_reg, res_valid_next;
    gsc_pkg::color_t            res_color_reg, res_color_next;
    logic                       res_overflow_reg, res_overflow_next;

    logic                       tbl_wr_en;
    logic [gsc_pkg::IDX_W-1:0]  tbl_wr_addr;
    gsc_pkg::pos_t              tbl_wr_pos;
    gsc_pkg::color_t            tbl_wr_color;
    logic [gsc_pkg::CNT_W-1:0]  walk_less;
    logic [gsc_pkg::CNT_W-1:0]  ahead_less;
    logic [gsc_pkg::IDX_W-1:0]  tbl_rd_addr;
    gsc_pkg::pos_t              tbl_rd_pos;
    gsc_pkg::color_t            tbl_rd_color;

    gsc_pkg::div_req_t          div_req;
    gsc_pkg::frac_t             div_quot;
    logic                       div_done;
    gsc_pkg::lerp_req_t         lerp_req;
    gsc_pkg::color_t            lerp_color;
    logic                       lerp_done;

    logic                       cmd_take;
    logic                       res_take;

    gsc_table u_table (
        .clk      (clk),
        .wr_en    (tbl_wr_en),
        .wr_addr  (tbl_wr_addr),
        .wr_pos   (tbl_wr_pos),
        .wr_color (tbl_wr_color),
        .rd_addr  (tbl_rd_addr),
        .rd_pos   (tbl_rd_pos),
        .rd_color (tbl_rd_color)
    );

    gsc_div u_div (
        .clk   (clk),
        .rst_n (rst_n),
        .req   (div_req),
        .quot  (div_quot),
        .done  (div_done)
    );

    gsc_lerp u_lerp (
        .clk   (clk),
        .rst_n (rst_n),
        .req   (lerp_req),
        .color (lerp_color),
        .done  (lerp_done)
    );

    assign cmd_stall = state_reg != ST_IDLE;
    assign cmd_take  = cmd_valid && !cmd_stall;
    assign res_take  = res_valid_reg && !res_stall;

    // The table read is registered, so its address is formed from the next walk pointer.
    // During an insert the walk pointer names the free slot and the read data holds the
    // entry just below it; during a sample the read data is the scanned entry.
    assign walk_less   = walk_reg - 1'b1;
    assign ahead_less  = walk_next - 1'b1;
    assign tbl_rd_addr = (state_next == ST_INS) ? ahead_less[gsc_pkg::IDX_W-1:0]
                                                : walk_next[gsc_pkg::IDX_W-1:0];

    always_comb
    begin
        state_next        = state_reg;
        count_next        = count_reg;
        overflow_next     = overflow_reg;
        walk_next         = walk_reg;
        t_next            = t_reg;
        new_color_next    = new_color_reg;
        prev_pos_next     = prev_pos_reg;
        prev_color_next   = prev_color_reg;
        cur_color_next    = cur_color_reg;
        result_next       = result_reg;
        res_valid_next    = res_valid_reg && !res_take;
        res_color_next    = res_color_reg;
        res_overflow_next = res_overflow_reg;

        tbl_wr_en    = 1'b0;
        tbl_wr_addr  = walk_reg[gsc_pkg::IDX_W-1:0];
        tbl_wr_pos   = t_reg;
        tbl_wr_color = new_color_reg;

        div_req.start = 1'b0;
        div_req.num   = t_reg - prev_pos_reg;
        div_req.den   = tbl_rd_pos - prev_pos_reg;

        lerp_req.start   = 1'b0;
        lerp_req.color_a = prev_color_reg;
        lerp_req.color_b = cur_color_reg;
        lerp_req.frac    = div_quot;

        unique case (state_reg)
            ST_IDLE:
            begin
                if (cmd_take)
                begin
                    t_next         = gsc_pkg::fit_position(position);
                    new_color_next = {red, green, blue, alpha};
                    case (cmd)
                        gsc_pkg::CMD_CLEAR:
                        begin
                            count_next = '0;
                        end
                        gsc_pkg::CMD_INSERT:
                        begin
                            if (count_reg == gsc_pkg::CNT_W'(gsc_pkg::MAX_STOPS))
                            begin
                                overflow_next = 1'b1;
                            end
                            else
                            begin
                                walk_next  = count_reg;
                                state_next = ST_INS;
                            end
                        end
                        gsc_pkg::CMD_SAMPLE:
                        begin
                            if (count_reg == '0)
                            begin
                                result_next = '0;
                                state_next  = ST_DONE;
                            end
                            else
                            begin
                                walk_next  = '0;
                                state_next = ST_SCAN;
                            end
                        end
                        default:
                        begin
                        end
                    endcase
                end
            end

            ST_INS:
            begin
                tbl_wr_en = 1'b1;
                if (walk_reg != '0 && tbl_rd_pos > t_reg)
                begin
                    // Move the larger stop up one slot and keep walking down.
                    tbl_wr_pos   = tbl_rd_pos;
                    tbl_wr_color = tbl_rd_color;
                    walk_next    = walk_less;
                end
                else
                begin
                    count_next = count_reg + 1'b1;
                    state_next = ST_IDLE;
                end
            end

            ST_SCAN:
            begin
                if (walk_reg == count_reg)
                begin
                    // Past the last stop: return the last color.
                    result_next = prev_color_reg;
                    state_next  = ST_DONE;
                end
                else if (walk_reg == '0)
                begin
                    if (count_reg == gsc_pkg::CNT_W'(1) || t_reg <= tbl_rd_pos)
                    begin
                        result_next = tbl_rd_color;
                        state_next  = ST_DONE;
                    end
                    else
                    begin
                        prev_pos_next   = tbl_rd_pos;
                        prev_color_next = tbl_rd_color;
                        walk_next       = walk_reg + 1'b1;
                    end
                end
                else if (t_reg <= tbl_rd_pos)
                begin
                    cur_color_next = tbl_rd_color;
                    div_req.start  = 1'b1;
                    state_next     = ST_DIV;
                end
                else
                begin
                    prev_pos_next   = tbl_rd_pos;
                    prev_color_next = tbl_rd_color;
                    walk_next       = walk_reg + 1'b1;
                end
            end

            ST_DIV:
            begin
                if (div_done)
                begin
                    lerp_req.start = 1'b1;
                    state_next     = ST_LERP;
                end
            end

            ST_LERP:
            begin
                if (lerp_done)
                begin
                    result_next = lerp_color;
                    state_next  = ST_DONE;
                end
            end

            ST_DONE:
            begin
                if (!res_valid_reg || res_take)
                begin
                    res_valid_next    = 1'b1;
                    res_color_next    = result_reg;
                    res_overflow_next = overflow_reg;
                    state_next        = ST_IDLE;
                end
            end

            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= ST_IDLE;
            count_reg     <= '0;
            overflow_reg  <= 1'b0;
            res_valid_reg <= 1'b0;
            walk_reg      <= '0;
        end
        else
        begin
            state_reg     <= state_next;
            count_reg     <= count_next;
            overflow_reg  <= overflow_next;
            res_valid_reg <= res_valid_next;
            walk_reg      <= walk_next;
        end
    end

    always_ff @(posedge clk)
    begin
        t_reg            <= t_next;
        new_color_reg    <= new_color_next;
        prev_pos_reg     <= prev_pos_next;
        prev_color_reg   <= prev_color_next;
        cur_color_reg    <= cur_color_next;
        result_reg       <= result_next;
        res_color_reg    <= res_color_next;
        res_overflow_reg <= res_overflow_next;
    end

    assign res_valid    = res_valid_reg;
    assign out_red      = res_color_reg[31:24];
    assign out_green    = res_color_reg[23:16];
    assign out_blue     = res_color_reg[15:8];
    assign out_alpha    = res_color_reg[7:0];
    assign out_overflow = res_overflow_reg;

endmodule

@@ tb/gsc_sample_checker.sv @@
`timescale 1ns / 100ps
// Checker for the gradient stop color sampler: watches both channels, predicts each sample
// from its own copy of the stop table and compares the returned color field by field.
// Depends on gsc_pkg for the command codes, the table depth and the position and color types.
module gsc_sample_checker (
    input  logic        clk,
    input  logic        rst_n,
    input  logic        cmd_valid,
    input  logic        cmd_stall,
    input  logic [1:0]  cmd,
    input  logic [15:0] position,
    input  logic [7:0]  red,
    input  logic [7:0]  green,
    input  logic [7:0]  blue,
    input  logic [7:0]  alpha,
    input  logic        res_valid,
    input  logic        res_stall,
    input  logic [7:0]  out_red,
    input  logic [7:0]  out_green,
    input  logic [7:0]  out_blue,
    input  logic [7:0]  out_alpha,
    input  logic        out_overflow,
    output int          fail_count,
    output int          pending
);

    typedef struct packed {
        logic [7:0] red;
        logic [7:0] green;
        logic [7:0] blue;
        logic [7:0] alpha;
        logic       overflow;
    } sampled_color_t;

    gsc_pkg::pos_t   stop_pos  [gsc_pkg::MAX_STOPS];
    gsc_pkg::color_t stop_rgba [gsc_pkg::MAX_STOPS];
    int              held_stops;
    logic            sticky_overflow;
    sampled_color_t  expected_colors[$];
    int              mismatches;

    initial
    begin
        fail_count = 0;
        pending    = 0;
        mismatches = 0;
    end

    // Per-channel blend with round half up; f is Q1.16 in 0..65536.
    function automatic gsc_pkg::color_t blend(input gsc_pkg::color_t ca,
                                              input gsc_pkg::color_t cb,
                                              input logic [16:0] f);
        gsc_pkg::color_t mix;
        logic [31:0]     v;
        int              s;
        for (s = 0; s < 32; s += 8)
        begin
            v = ca[s+:8] * (32'd65536 - f) + cb[s+:8] * f + 32'd32768;
            mix[s+:8] = v[23:16];
        end
        return mix;
    endfunction

    function automatic gsc_pkg::color_t color_at(input gsc_pkg::pos_t t);
        logic [32:0] num;
        logic [16:0] f;
        int          i;
        if (held_stops == 0)
            return '0;
        if (held_stops == 1 || t <= stop_pos[0])
            return stop_rgba[0];
        for (i = 1; i < held_stops; i++)
        begin
            if (t <= stop_pos[i])
            begin
                f = '0;
                if (stop_pos[i] > stop_pos[i-1] && t > stop_pos[i-1])
                begin
                    num = {17'd0, t - stop_pos[i-1]} << 16;
                    f   = 17'(num / (stop_pos[i] - stop_pos[i-1]));
                end
                return blend(stop_rgba[i-1], stop_rgba[i], f);
            end
        end
        return stop_rgba[held_stops-1];
    endfunction

    // Sorted insertion: the new stop lands after every stop of equal position.
    task automatic add_stop(input gsc_pkg::pos_t p, input gsc_pkg::color_t c);
        int k;
        if (held_stops >= gsc_pkg::MAX_STOPS)
        begin
            sticky_overflow = 1'b1;
            return;
        end
        k = held_stops;
        while (k > 0 && stop_pos[k-1] > p)
        begin
            stop_pos[k]  = stop_pos[k-1];
            stop_rgba[k] = stop_rgba[k-1];
            k--;
        end
        stop_pos[k]  = p;
        stop_rgba[k] = c;
        held_stops++;
    endtask

    always @(posedge clk or negedge rst_n)
    begin : watch
        sampled_color_t  got;
        sampled_color_t  want;
        gsc_pkg::color_t c;
        if (!rst_n)
        begin
            held_stops      = 0;
            sticky_overflow = 1'b0;
            expected_colors.delete();
        end
        else
        begin
            // Results first, so a sample accepted on this edge never answers itself.
            if (res_valid && !res_stall)
            begin
                got = '{out_red, out_green, out_blue, out_alpha, out_overflow};
                if (expected_colors.size() == 0)
                begin
                    mismatches++;
                    if (mismatches <= 10)
                        $display("%0t: unexpected result r=%02h g=%02h b=%02h a=%02h ovf=%0b",
                                 $time, got.red, got.green, got.blue, got.alpha, got.overflow);
                end
                else
                begin
                    want = expected_colors.pop_front();
                    if (got.red !== want.red || got.green !== want.green ||
                        got.blue !== want.blue || got.alpha !== want.alpha ||
                        got.overflow !== want.overflow)
                    begin
                        mismatches++;
                        if (mismatches <= 10)
                            $display({"%0t: color mismatch, expected r=%02h g=%02h b=%02h ",
                                      "a=%02h ovf=%0b, got r=%02h g=%02h b=%02h a=%02h ovf=%0b"},
                                     $time, want.red, want.green, want.blue, want.alpha,
                                     want.overflow, got.red, got.green, got.blue, got.alpha,
                                     got.overflow);
                    end
                end
            end
            if (cmd_valid && !cmd_stall)
            begin
                case (cmd)
                    gsc_pkg::CMD_CLEAR:
                        held_stops = 0;
                    gsc_pkg::CMD_INSERT:
                        add_stop(position, {red, green, blue, alpha});
                    gsc_pkg::CMD_SAMPLE:
                    begin
                        c = color_at(position);
                        expected_colors.push_back('{c[31:24], c[23:16], c[15:8], c[7:0],
                                                    sticky_overflow});
                    end
                    default:
                        ;
                endcase
            end
        end
        pending    <= expected_colors.size();
        fail_count <= mismatches;
    end

endmodule

@@ tb/tb_gradient_stop_color_sampler.sv @@
`timescale 1ns / 100ps
// Testbench top for the gradient stop color sampler: clock, reset, command stimulus,
// result-side stall pattern and the verdict. Depends on gsc_pkg, the block and gsc_sample_checker.
module tb_gradient_stop_color_sampler;

    localparam int         CLK_HALF     = 6;
    localparam int         CYCLE_LIMIT  = 400000;
    localparam int         RANDOM_ITEMS = 700;
    localparam int         QUIET_AFTER  = 600;
    localparam int         HOLD_AFTER   = 200;
    localparam int         HOLD_CYCLES  = 300;
    localparam int         DRAIN_CYCLES = 60;
    localparam logic [1:0] CMD_UNUSED   = 2'd3;

    logic        clk = 1'b0;
    logic        rst_n;
    logic        cmd_valid;
    logic        cmd_stall;
    logic [1:0]  cmd;
    logic [15:0] position;
    logic [7:0]  red;
    logic [7:0]  green;
    logic [7:0]  blue;
    logic [7:0]  alpha;
    logic        res_valid;
    logic        res_stall;
    logic [7:0]  out_red;
    logic [7:0]  out_green;
    logic [7:0]  out_blue;
    logic [7:0]  out_alpha;
    logic        out_overflow;

    int fail_count;
    int pending;
    int cycles = 0;

    // Idling controls shared by the command and the result side. The last part of the run
    // is quiet: no gaps on the command side and no stalls on the result side.
    int  gap_pct   = 20;
    int  stall_pct = 20;
    bit  quiet     = 1'b0;
    bit  hold_request = 1'b0;
    bit  hold_served  = 1'b0;

    // Count of non-ignored transactions sent in the random part.
    int            items_sent = 0;
    // Positions inserted since the last clear; samples aim at them and their neighbors.
    gsc_pkg::pos_t placed[$];

    always #(CLK_HALF) clk = ~clk;

    gradient_stop_color_sampler u_top (
        .clk          (clk),
        .rst_n        (rst_n),
        .cmd_valid    (cmd_valid),
        .cmd_stall    (cmd_stall),
        .cmd          (cmd),
        .position     (position),
        .red          (red),
        .green        (green),
        .blue         (blue),
        .alpha        (alpha),
        .res_valid    (res_valid),
        .res_stall    (res_stall),
        .out_red      (out_red),
        .out_green    (out_green),
        .out_blue     (out_blue),
        .out_alpha    (out_alpha),
        .out_overflow (out_overflow)
    );

    gsc_sample_checker u_check (
        .clk          (clk),
        .rst_n        (rst_n),
        .cmd_valid    (cmd_valid),
        .cmd_stall    (cmd_stall),
        .cmd          (cmd),
        .position     (position),
        .red          (red),
        .green        (green),
        .blue         (blue),
        .alpha        (alpha),
        .res_valid    (res_valid),
        .res_stall    (res_stall),
        .out_red      (out_red),
        .out_green    (out_green),
        .out_blue     (out_blue),
        .out_alpha    (out_alpha),
        .out_overflow (out_overflow),
        .fail_count   (fail_count),
        .pending      (pending)
    );

    // Watchdog. The slowest correct run is roughly 800 transactions, each taking the longest
    // block time plus the longest gap and the longest stall, plus the long hold; the limit
    // leaves several times that.
    always @(posedge clk)
    begin
        cycles <= cycles + 1;
        if (cycles >= CYCLE_LIMIT)
        begin
            $display("** gradient_stop_color_sampler: FAILED **");
            $finish;
        end
    end

    // Result side. Stalls come in random bursts; once during the run the receiver holds
    // off for a long stretch so that the output register fills and the block stalls its
    // command input while the sender keeps offering transactions.
    initial
    begin
        res_stall <= 1'b0;
        forever
        begin
            @(posedge clk);
            if (hold_request && !hold_served)
            begin
                res_stall <= 1'b1;
                repeat (HOLD_CYCLES) @(posedge clk);
                res_stall <= 1'b0;
                hold_served = 1'b1;
            end
            else if (!quiet && $urandom_range(99) < stall_pct)
            begin
                res_stall <= 1'b1;
                repeat ($urandom_range(1, 14)) @(posedge clk);
                res_stall <= 1'b0;
            end
        end
    end

    function automatic logic [7:0] rand_byte();
        return 8'($urandom);
    endfunction

    function automatic gsc_pkg::pos_t rand_pos();
        return gsc_pkg::pos_t'($urandom);
    endfunction

    // Offers one command transaction and returns at the edge where it is accepted. Valid
    // stays high between back-to-back transactions; it only drops for an idle burst.
    task automatic send(input logic [1:0] c, input gsc_pkg::pos_t p,
                        input logic [7:0] r, input logic [7:0] g,
                        input logic [7:0] b, input logic [7:0] a);
        if (!quiet && $urandom_range(99) < gap_pct)
        begin
            cmd_valid <= 1'b0;
            repeat ($urandom_range(1, 14)) @(posedge clk);
        end
        cmd_valid <= 1'b1;
        cmd       <= c;
        position  <= p;
        red       <= r;
        green     <= g;
        blue      <= b;
        alpha     <= a;
        do
            @(posedge clk);
        while (cmd_stall);
        if (c != CMD_UNUSED)
            items_sent++;
    endtask

    // Clear carries random junk in the payload so every field bit still toggles.
    task automatic clear_table();
        send(gsc_pkg::CMD_CLEAR, rand_pos(), rand_byte(), rand_byte(), rand_byte(),
             rand_byte());
        placed.delete();
    endtask

    task automatic insert_stop(input gsc_pkg::pos_t p);
        send(gsc_pkg::CMD_INSERT, p, rand_byte(), rand_byte(), rand_byte(), rand_byte());
        placed.push_back(p);
    endtask

    task automatic sample_at(input gsc_pkg::pos_t p);
        send(gsc_pkg::CMD_SAMPLE, p, rand_byte(), rand_byte(), rand_byte(), rand_byte());
    endtask

    // The unused command code must be swallowed without a result.
    task automatic send_noise();
        send(CMD_UNUSED, rand_pos(), rand_byte(), rand_byte(), rand_byte(), rand_byte());
    endtask

    // Sample positions favor the ends of the range, the stops themselves and their
    // immediate neighbors, where segment selection and the fraction edges are decided.
    function automatic gsc_pkg::pos_t pick_sample_pos();
        int            sel;
        gsc_pkg::pos_t p;
        sel = $urandom_range(9);
        p   = rand_pos();
        if (sel == 0)
            p = '0;
        else if (sel == 1)
            p = '1;
        else if (sel <= 6 && placed.size() > 0)
        begin
            p = placed[$urandom_range(placed.size() - 1)];
            if (sel == 5)
                p = p + 1'b1;
            else if (sel == 6)
                p = p - 1'b1;
        end
        return p;
    endfunction

    // Stop positions follow one of several layouts per table: spread over the whole
    // range, packed into a narrow cluster, drawn from a few repeated values, or pinned
    // to the extremes.
    function automatic gsc_pkg::pos_t pick_stop_pos(input int layout, input gsc_pkg::pos_t base);
        gsc_pkg::pos_t p;
        case (layout)
            0:       p = rand_pos();
            1:       p = base + gsc_pkg::pos_t'($urandom_range(0, 63));
            2:       p = base + gsc_pkg::pos_t'($urandom_range(0, 3) * 16'h1000);
            default: p = ($urandom_range(1) == 1) ? '1 : '0;
        endcase
        return p;
    endfunction

    // One well-formed ramp: usually a clear, a batch of stops, then several samples.
    // A little noise is mixed in between the stops.
    task automatic build_and_sample(input int n_stops, input bit do_clear);
        int            layout;
        int            k;
        gsc_pkg::pos_t base;
        layout = $urandom_range(3);
        base   = rand_pos();
        if (do_clear)
            clear_table();
        for (k = 0; k < n_stops; k++)
        begin
            if ($urandom_range(19) == 0)
                send_noise();
            insert_stop(pick_stop_pos(layout, base));
        end
        repeat ($urandom_range(1, 6)) sample_at(pick_sample_pos());
    endtask

    initial
    begin : stimulus
        int seq_idx;
        int idle_choice;

        rst_n     <= 1'b0;
        cmd_valid <= 1'b0;
        cmd       <= gsc_pkg::CMD_CLEAR;
        position  <= '0;
        red       <= '0;
        green     <= '0;
        blue      <= '0;
        alpha     <= '0;
        repeat (10) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // Directed part. An empty table returns transparent black at both ends of the range.
        sample_at(16'h0000);
        sample_at(16'hFFFF);
        // A single stop answers every sample with its own color.
        send(gsc_pkg::CMD_INSERT, 16'h8000, 8'hFF, 8'h00, 8'h80, 8'h7F);
        sample_at(16'h0000);
        sample_at(16'hFFFF);
        // Stops at both extremes plus a second stop at an equal position, which must
        // land after the first one.
        send(gsc_pkg::CMD_INSERT, 16'h0000, 8'h00, 8'hFF, 8'h00, 8'hFF);
        send(gsc_pkg::CMD_INSERT, 16'hFFFF, 8'hFF, 8'hFF, 8'hFF, 8'hFF);
        send(gsc_pkg::CMD_INSERT, 16'h8000, 8'h10, 8'h20, 8'h30, 8'h40);
        sample_at(16'h0000);
        sample_at(16'h0001);
        sample_at(16'h4000);
        sample_at(16'h8000);
        sample_at(16'h8001);
        sample_at(16'hFFFE);
        sample_at(16'hFFFF);
        send(CMD_UNUSED, 16'hFFFF, 8'hFF, 8'hFF, 8'hFF, 8'hFF);
        sample_at(16'h8000);
        // A clear leaves the table empty again.
        send(gsc_pkg::CMD_CLEAR, 16'hFFFF, 8'hFF, 8'hFF, 8'hFF, 8'hFF);
        placed.delete();
        sample_at(16'h1234);

        // Random part. The first ramp overfills the table so the sticky overflow flag is
        // exercised early; after that the stop count per table is random, now and then
        // past the depth, and some tables are extended without a clear.
        items_sent = 0;
        seq_idx    = 0;
        while (items_sent < RANDOM_ITEMS)
        begin
            if (items_sent >= QUIET_AFTER)
            begin
                quiet     = 1'b1;
                gap_pct   = 0;
                stall_pct = 0;
            end
            else if (seq_idx % 4 == 0)
            begin
                // Switch the idling profile now and then, including stretches without any.
                idle_choice = $urandom_range(2);
                gap_pct     = (idle_choice == 0) ? 0 : (idle_choice == 1) ? 10 : 35;
                idle_choice = $urandom_range(2);
                stall_pct   = (idle_choice == 0) ? 0 : (idle_choice == 1) ? 10 : 35;
            end
            if (items_sent >= HOLD_AFTER)
                hold_request = 1'b1;
            if (seq_idx == 0)
                build_and_sample(gsc_pkg::MAX_STOPS + 1, 1'b1);
            else
                build_and_sample(($urandom_range(9) == 0) ? $urandom_range(14, 18)
                                                           : $urandom_range(0, 10),
                                 $urandom_range(7) != 0);
            seq_idx++;
        end
        cmd_valid <= 1'b0;

        // Drain: wait until every sample has come back, then give the block time to show
        // any stray result.
        @(posedge clk);
        while (pending != 0)
            @(posedge clk);
        repeat (DRAIN_CYCLES) @(posedge clk);

        if (fail_count == 0)
            $display("** gradient_stop_color_sampler: PASSED **");
        else
            $display("** gradient_stop_color_sampler: FAILED **");
        $finish;
    end

endmodule
